@@ rtl/pq_adc_distance_scan_defines.svh @@
// Assertion macros shared by the distance scan RTL.
// Used by files that assert; expects i_clk and i_rst_n in the including module.
`ifndef PQ_ADC_DISTANCE_SCAN_DEFINES_SVH
`define PQ_ADC_DISTANCE_SCAN_DEFINES_SVH

`ifndef SYNTH
// Check a property on every clock edge outside reset
`define PQADC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// Check that a condition leads to a consequence on the next edge
`define PQADC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PQADC_ASSERT(lbl, prop, msg)
`define PQADC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ rtl/pqadc_pkg.sv @@
// Shared types and constants for the PQ asymmetric distance scan.
// No dependencies; imported by the lane, merge and top-level modules.
`timescale 1ns / 1ps

package pqadc_pkg;

    // Fixed field widths
    localparam int TABLE_DEPTH    = 16384;
    localparam int ADDR_W         = $clog2(TABLE_DEPTH);
    localparam int VALUE_W        = 32;
    localparam int WORD_W         = 64;
    localparam int SUM_W          = 40;
    localparam int NSUB_W         = 7;
    localparam int SLOT_W         = 8;
    localparam int BYTE_W         = 8;
    localparam int NIBBLE_W       = 4;
    localparam int APB_ADDR_W     = 3;
    localparam int APB_DATA_W     = 32;

    // Lane layout: one lane per nibble of a code word
    localparam int NUM_LANES      = WORD_W / NIBBLE_W;
    localparam int BYTES_PER_WORD = WORD_W / BYTE_W;
    localparam int NUM_PAIRS      = NUM_LANES / 2;

    // Parameter defaults
    localparam int MAX_SUBSPACES_DEF = 64;
    localparam int MAX_CENTROIDS_DEF = 256;
    localparam int ENTRY_BITS_DEF    = 32;

    // Register reset values
    localparam logic              MODE_RESET = 1'b1;
    localparam logic [NSUB_W-1:0] NSUB_RESET = NSUB_W'(8);

    typedef enum logic {
        OP_TABLE_WRITE = 1'b0,
        OP_CODE_WORD   = 1'b1
    } t_opcode;

    typedef enum logic {
        REG_CODE_BITS_MODE = 1'b0,
        REG_NUM_SUBSPACES  = 1'b1
    } t_reg_idx;

    // Control from the slot tracker to every lane
    typedef struct packed {
        logic              rd_en;
        logic              code_acc;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic              mode8;
        logic [SLOT_W-1:0] slot_base;
        logic [SLOT_W-1:0] slot_limit;
    } t_lane_ctl;

    // Per-word tag that travels with the lookups into the merge pipeline
    typedef struct packed {
        logic valid;
        logic last;
        logic short_code;
    } t_word_ctl;

endpackage

@@ rtl/pq_adc_distance_scan.sv @@
// Top level of the PQ asymmetric distance scan: config registers, slot tracking,
// lanes and merge. Depends on pqadc_pkg, pqadc_lane, pqadc_merge and the macro header.
`timescale 1ns / 1ps
`include "pq_adc_distance_scan_defines.svh"

// Takes one item per clock: a table load writes one entry into all eight table copies,
// and a code word issues up to sixteen lookups at once (eight RAM copies, two read ports
// each), so words stream back to back with no gap. A distance appears on the output
// after the last word of a vector passes the table read at the accepting edge, the two
// registered adder tree levels and the accumulate into the result register. The input
// stalls only while a finished distance is still held in the result register and the
// next vector's last word reaches the accumulator. The table
// is not cleared after reset: an entry never written reads back undefined. Registers:
// byte 0 code_bits_mode (bit 0, 1 = 8-bit codes), byte 4 num_subspaces (bits 6:0);
// write them only with the scan idle.
module pq_adc_distance_scan #(
    parameter int MAX_SUBSPACES = pqadc_pkg::MAX_SUBSPACES_DEF,
    parameter int MAX_CENTROIDS = pqadc_pkg::MAX_CENTROIDS_DEF,
    parameter int ENTRY_BITS    = pqadc_pkg::ENTRY_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Request input
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [13:0] table_index, [45:14] table_value, [109:46] code_word, [111:110] zero
    input  logic [111:0]                        s_axis_tdata,
    // [0] opcode
    input  logic [0:0]                          s_axis_tuser,
    input  logic                                s_axis_tlast,
    // Result output
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [39:0] distance
    output logic [pqadc_pkg::SUM_W-1:0]         m_axis_tdata,
    // [0] short_code
    output logic [0:0]                          m_axis_tuser,
    // Configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pqadc_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [pqadc_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [pqadc_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                pready
);
    import pqadc_pkg::*;

    logic                    r_code_bits_mode;
    logic [NSUB_W-1:0]       r_num_subspaces;
    logic [SLOT_W-1:0]       r_slots_done;
    logic [SLOT_W-1:0]       n_slots_done;
    logic [SLOT_W-1:0]       limit;
    logic [SLOT_W-1:0]       per_word;
    logic [SLOT_W-1:0]       slots_sum;
    logic [SLOT_W-1:0]       covered;
    logic                    short_code;
    logic                    cfg_wr;
    logic                    adv;
    logic                    in_acc;
    logic                    code_acc;
    logic                    tbl_acc;
    logic [ADDR_W-1:0]       table_index;
    logic [VALUE_W-1:0]      table_value;
    logic [WORD_W-1:0]       code_word;
    t_lane_ctl               lane_ctl;
    t_word_ctl               r_s1_ctl;
    logic signed [ENTRY_BITS-1:0] entry [NUM_LANES];
    logic signed [SUM_W-1:0] distance;
    logic                    out_short;

    // Unpack the request
    assign table_index = s_axis_tdata[ADDR_W-1:0];
    assign table_value = s_axis_tdata[ADDR_W +: VALUE_W];
    assign code_word   = s_axis_tdata[ADDR_W + VALUE_W +: WORD_W];

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_bits_mode <= MODE_RESET;
            r_num_subspaces  <= NSUB_RESET;
        end else if (cfg_wr) begin
            unique case (t_reg_idx'(paddr[2]))
                REG_CODE_BITS_MODE: r_code_bits_mode <= pwdata[0];
                REG_NUM_SUBSPACES:  r_num_subspaces  <= pwdata[NSUB_W-1:0];
                default:            ;
            endcase
        end
    end

    always_comb begin
        unique case (t_reg_idx'(paddr[2]))
            REG_CODE_BITS_MODE: prdata = APB_DATA_W'(r_code_bits_mode);
            REG_NUM_SUBSPACES:  prdata = APB_DATA_W'(r_num_subspaces);
            default:            prdata = '0;
        endcase
    end

    // Accept
    assign s_axis_tready = adv;
    assign in_acc   = s_axis_tvalid && adv;
    assign code_acc = in_acc && (s_axis_tuser == OP_CODE_WORD);
    assign tbl_acc  = in_acc && (s_axis_tuser == OP_TABLE_WRITE);

    // Slot tracking: saturate coverage at the active subspace count
    assign limit     = (SLOT_W'(r_num_subspaces) > SLOT_W'(MAX_SUBSPACES))
                       ? SLOT_W'(MAX_SUBSPACES) : SLOT_W'(r_num_subspaces);
    assign per_word  = r_code_bits_mode ? SLOT_W'(BYTES_PER_WORD) : SLOT_W'(NUM_LANES);
    assign slots_sum = r_slots_done + per_word;
    assign covered   = (r_slots_done >= limit) ? r_slots_done :
                       (slots_sum > limit)     ? limit : slots_sum;
    assign short_code = covered < limit;

    always_comb begin
        n_slots_done = r_slots_done;
        if (code_acc) begin
            n_slots_done = s_axis_tlast ? '0 : covered;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots_done <= '0;
        end else begin
            r_slots_done <= n_slots_done;
        end
    end

    // Tag the word in step with the table reads; the short flag only rides on a last word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctl <= '0;
        end else if (adv) begin
            r_s1_ctl.valid      <= code_acc;
            r_s1_ctl.last       <= s_axis_tlast;
            r_s1_ctl.short_code <= short_code && s_axis_tlast;
        end
    end

    // Lane control
    assign lane_ctl.rd_en      = adv;
    assign lane_ctl.code_acc   = code_acc;
    assign lane_ctl.wr_en      = tbl_acc;
    assign lane_ctl.wr_addr    = table_index;
    assign lane_ctl.mode8      = r_code_bits_mode;
    assign lane_ctl.slot_base  = r_slots_done;
    assign lane_ctl.slot_limit = limit;

    for (genvar p = 0; p < NUM_PAIRS; p++) begin : g_lane
        pqadc_lane #(
            .MAX_CENTROIDS (MAX_CENTROIDS),
            .ENTRY_BITS    (ENTRY_BITS),
            .PAIR          (p)
        ) u_lane (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (lane_ctl),
            .i_code_word (code_word),
            .i_wr_data   (table_value[ENTRY_BITS-1:0]),
            .o_entry_a   (entry[2 * p]),
            .o_entry_b   (entry[2 * p + 1])
        );
    end

    pqadc_merge #(
        .ENTRY_BITS (ENTRY_BITS)
    ) u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_entry      (entry),
        .i_ctl        (r_s1_ctl),
        .o_adv        (adv),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_distance   (distance),
        .o_short_code (out_short)
    );

    assign m_axis_tdata = distance;
    assign m_axis_tuser = out_short;

    `PQADC_ASSERT_NEXT(a_slots_clear, code_acc && s_axis_tlast, r_slots_done == '0, "slot count not cleared")
    `PQADC_ASSERT(a_short_last, (r_s1_ctl.valid && r_s1_ctl.short_code) |-> r_s1_ctl.last, "short flag off a last word")
    `PQADC_ASSERT(a_stall_cause, !s_axis_tready |-> m_axis_tvalid, "stall without a pending result")

endmodule

@@ rtl/pqadc_ram.sv @@
// Generic single-write, dual-read RAM with registered read data.
// No dependencies; holds one copy of the distance table per lane pair.
`timescale 1ns / 1ps

module pqadc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_b,
    output logic [WIDTH-1:0]         o_rd_data_a,
    output logic [WIDTH-1:0]         o_rd_data_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_a;
    logic [WIDTH-1:0] r_rd_b;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read ports, hold data while disabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_a <= r_mem[i_rd_addr_a];
            r_rd_b <= r_mem[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

@@ rtl/pqadc_lane.sv @@
// Lookup lane pair: two code slots, address generation and one table copy.
// Depends on pqadc_pkg and pqadc_ram.
`timescale 1ns / 1ps

module pqadc_lane #(
    parameter int MAX_CENTROIDS = pqadc_pkg::MAX_CENTROIDS_DEF,
    parameter int ENTRY_BITS    = pqadc_pkg::ENTRY_BITS_DEF,
    parameter int PAIR          = 0
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  pqadc_pkg::t_lane_ctl              i_ctl,
    input  logic [pqadc_pkg::WORD_W-1:0]      i_code_word,
    input  logic [ENTRY_BITS-1:0]             i_wr_data,
    output logic signed [ENTRY_BITS-1:0]      o_entry_a,
    output logic signed [ENTRY_BITS-1:0]      o_entry_b
);
    import pqadc_pkg::*;

    // Byte values at or above a multiple of the centroid count wrap
    localparam int QMAX = 255 / MAX_CENTROIDS;
    localparam int Q_W  = $clog2(QMAX + 2);

    logic [ADDR_W-1:0]     rd_addr [2];
    logic [1:0]            active;
    logic [1:0]            r_active;
    logic [ENTRY_BITS-1:0] rd_data_a;
    logic [ENTRY_BITS-1:0] rd_data_b;

    for (genvar s = 0; s < 2; s++) begin : g_sub
        localparam int J  = 2 * PAIR + s;
        localparam int JB = J % BYTES_PER_WORD;

        logic [SLOT_W-1:0]   slot;
        logic [BYTE_W-1:0]   cbyte;
        logic [NIBBLE_W-1:0] nibble;
        logic [Q_W-1:0]      q;
        logic [ADDR_W-1:0]   base;
        logic [ADDR_W-1:0]   addr8;
        logic [ADDR_W-1:0]   addr4;

        assign slot   = i_ctl.slot_base + SLOT_W'(J);
        assign cbyte  = i_code_word[BYTE_W*JB +: BYTE_W];
        assign nibble = i_code_word[NIBBLE_W*J +: NIBBLE_W];

        // Count the centroid-count multiples the byte has passed
        always_comb begin
            q = '0;
            for (int i = 1; i <= QMAX; i++) begin
                if ({1'b0, cbyte} >= 9'(i * MAX_CENTROIDS)) begin
                    q = Q_W'(i);
                end
            end
        end

        // slot*K + (byte mod K) folded as (slot - q)*K + byte, modulo the depth
        assign base  = ADDR_W'(slot) - ADDR_W'(q);
        assign addr8 = ADDR_W'(base * ADDR_W'(MAX_CENTROIDS)) + ADDR_W'(cbyte);
        assign addr4 = ADDR_W'({slot, nibble});

        assign rd_addr[s] = i_ctl.mode8 ? addr8 : addr4;
        assign active[s]  = i_ctl.code_acc && (slot < i_ctl.slot_limit)
                            && (!i_ctl.mode8 || (J < BYTES_PER_WORD));
    end

    // Track which lookups count, aligned with the RAM read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
        end else if (i_ctl.rd_en) begin
            r_active <= active;
        end
    end

    pqadc_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk       (i_clk),
        .i_wr_en     (i_ctl.wr_en),
        .i_wr_addr   (i_ctl.wr_addr),
        .i_wr_data   (i_wr_data),
        .i_rd_en     (i_ctl.rd_en),
        .i_rd_addr_a (rd_addr[0]),
        .i_rd_addr_b (rd_addr[1]),
        .o_rd_data_a (rd_data_a),
        .o_rd_data_b (rd_data_b)
    );

    // Drop slots past the subspace count, lanes unused in 8-bit mode and non-code requests
    assign o_entry_a = r_active[0] ? rd_data_a : '0;
    assign o_entry_b = r_active[1] ? rd_data_b : '0;

endmodule

@@ rtl/pqadc_merge.sv @@
// Merge stage: registered adder tree over the lanes, running sum, result register.
// Depends on pqadc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "pq_adc_distance_scan_defines.svh"

module pqadc_merge #(
    parameter int ENTRY_BITS = pqadc_pkg::ENTRY_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic signed [ENTRY_BITS-1:0]        i_entry [pqadc_pkg::NUM_LANES],
    input  pqadc_pkg::t_word_ctl                i_ctl,
    output logic                                o_adv,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [pqadc_pkg::SUM_W-1:0]  o_distance,
    output logic                                o_short_code
);
    import pqadc_pkg::*;

    localparam int GROUP_SIZE = 4;
    localparam int NUM_GROUPS = NUM_LANES / GROUP_SIZE;
    localparam int GRP_W      = ENTRY_BITS + $clog2(GROUP_SIZE);
    localparam int TREE_W     = ENTRY_BITS + $clog2(NUM_LANES);

    logic signed [GRP_W-1:0]  grp_sum [NUM_GROUPS];
    logic signed [GRP_W-1:0]  r_a_sum [NUM_GROUPS];
    t_word_ctl                r_a_ctl;
    logic signed [TREE_W-1:0] tree_sum;
    logic signed [TREE_W-1:0] r_b_sum;
    t_word_ctl                r_b_ctl;
    logic signed [SUM_W-1:0]  r_acc;
    logic signed [SUM_W-1:0]  n_total;
    logic                     load_result;
    logic                     r_out_valid;
    logic signed [SUM_W-1:0]  r_out_distance;
    logic                     r_out_short;

    // Stall only when a finished vector meets a result still waiting
    assign o_adv = !(r_out_valid && !i_out_ready && r_b_ctl.valid && r_b_ctl.last);

    // First tree level: sums of lane groups
    always_comb begin
        for (int g = 0; g < NUM_GROUPS; g++) begin
            grp_sum[g] = '0;
            for (int k = 0; k < GROUP_SIZE; k++) begin
                grp_sum[g] = grp_sum[g] + GRP_W'(i_entry[g * GROUP_SIZE + k]);
            end
        end
    end

    // Second tree level: word sum
    always_comb begin
        tree_sum = '0;
        for (int g = 0; g < NUM_GROUPS; g++) begin
            tree_sum = tree_sum + TREE_W'(r_a_sum[g]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_a_sum <= grp_sum;
            r_b_sum <= tree_sum;
        end
    end

    // Advance word tags alongside the sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctl <= '0;
            r_b_ctl <= '0;
        end else if (o_adv) begin
            r_a_ctl <= i_ctl;
            r_b_ctl <= r_a_ctl;
        end
    end

    // Accumulate; the sum of at most 64 entries cannot leave the 40-bit range
    assign n_total     = r_acc + SUM_W'(r_b_sum);
    assign load_result = o_adv && r_b_ctl.valid && r_b_ctl.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (o_adv && r_b_ctl.valid) begin
            r_acc <= r_b_ctl.last ? '0 : n_total;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_result) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_result) begin
            r_out_distance <= n_total;
            r_out_short    <= r_b_ctl.short_code;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_distance   = r_out_distance;
    assign o_short_code = r_out_short;

    `PQADC_ASSERT_NEXT(a_acc_clear, load_result, r_acc == '0, "running sum not cleared")
    `PQADC_ASSERT(a_no_overwrite, (r_out_valid && !i_out_ready) |-> !load_result, "held result overwritten")
    `PQADC_ASSERT(a_rise_src, $rose(r_out_valid) |-> $past(r_b_ctl.valid && r_b_ctl.last), "result without last word")

endmodule

@@ tb/sv/pq_adc_distance_scan_test.sv @@
// Self-checking testbench for the PQ asymmetric distance scan: table loads, code words, APB config.
// Depends on pqadc_pkg and pq_adc_distance_scan; predicts every distance and compares in order.
`timescale 1ns / 1ps

module pq_adc_distance_scan_test;
    import pqadc_pkg::*;

    localparam int LONG_HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES    = 8;
    localparam int DRAIN_LIMIT      = 4000;
    localparam int RANDOM_REQUESTS  = 1300;
    localparam int TIMEOUT_NS       = 12_000_000;
    localparam int MAX_REPORTS      = 50;
    localparam logic [VALUE_W-1:0] VALUE_MAX = 32'h7FFF_FFFF;
    localparam logic [VALUE_W-1:0] VALUE_MIN = 32'h8000_0000;
    // Byte codes alternating centroid 0 and centroid 255, slot 0 first
    localparam logic [WORD_W-1:0]  ALT_BYTES = 64'hFF00_FF00_FF00_FF00;

    typedef struct {
        logic [SUM_W-1:0] distance;
        logic             short_code;
    } t_scan_result;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    // [13:0] table_index, [45:14] table_value, [109:46] code_word, [111:110] zero
    logic [111:0]            s_axis_tdata = '0;
    // [0] opcode
    logic [0:0]              s_axis_tuser = '0;
    logic                    s_axis_tlast = 1'b0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    // [39:0] distance
    logic [SUM_W-1:0]        m_axis_tdata;
    // [0] short_code
    logic [0:0]              m_axis_tuser;
    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]   paddr = '0;
    logic [APB_DATA_W-1:0]   pwdata = '0;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;

    // Shadow of the block: distance table, running vector state and registers
    logic signed [VALUE_W-1:0] dist_table [TABLE_DEPTH];
    bit                        dist_written [TABLE_DEPTH];
    logic signed [SUM_W-1:0]   scan_sum;
    int                        scan_slots;
    logic                      cfg_mode8;
    logic [NSUB_W-1:0]         cfg_nsub;
    t_scan_result              pending_distances [$];

    int send_gap_max = 18;
    int recv_gap_max = 18;
    int sink_hold_left = 0;
    int requests_sent = 0;
    int mismatch_count = 0;

    pq_adc_distance_scan uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t: MISMATCH %s", $time, what);
    endtask

    function automatic int active_slots();
        return (cfg_nsub > MAX_SUBSPACES_DEF) ? MAX_SUBSPACES_DEF : int'(cfg_nsub);
    endfunction

    function automatic int centroids();
        return cfg_mode8 ? MAX_CENTROIDS_DEF : (1 << NIBBLE_W);
    endfunction

    function automatic int codes_per_word();
        return cfg_mode8 ? BYTES_PER_WORD : NUM_LANES;
    endfunction

    // Fold one accepted request into the shadow state; queue a distance on a last word
    function automatic void accumulate_distance(input t_opcode op,
                                                input logic [ADDR_W-1:0] idx,
                                                input logic [VALUE_W-1:0] val,
                                                input logic [WORD_W-1:0] word,
                                                input logic last);
        int active;
        int cid;
        logic [ADDR_W-1:0] addr;
        if (op == OP_TABLE_WRITE) begin
            dist_table[idx] = val;
            dist_written[idx] = 1'b1;
            return;
        end
        active = active_slots();
        // Slots past the subspace count fall through without summing
        for (int j = 0; j < codes_per_word() && scan_slots < active; j++) begin
            cid = cfg_mode8 ? word[BYTE_W*j +: BYTE_W] : word[NIBBLE_W*j +: NIBBLE_W];
            addr = ADDR_W'(scan_slots * centroids() + cid);
            scan_sum = scan_sum + dist_table[addr];
            scan_slots++;
        end
        if (last) begin
            pending_distances.push_back('{scan_sum, scan_slots < active});
            scan_sum = '0;
            scan_slots = 0;
        end
    endfunction

    function automatic logic [VALUE_W-1:0] draw_value();
        case ($urandom_range(7, 0))
            0: return VALUE_MAX;
            1: return VALUE_MIN;
            default: return $urandom;
        endcase
    endfunction

    function automatic int draw_gap_limit();
        case ($urandom_range(3, 0))
            0: return 0;
            1: return 3;
            default: return 18;
        endcase
    endfunction

    // Mostly small counts, with the extremes and saturating values mixed in
    function automatic logic [APB_DATA_W-1:0] draw_subspaces();
        logic [APB_DATA_W-1:0] data;
        data = $urandom;
        case ($urandom_range(19, 0))
            0:       data[NSUB_W-1:0] = '0;
            1:       data[NSUB_W-1:0] = NSUB_W'(1);
            2, 3:    data[NSUB_W-1:0] = NSUB_W'(MAX_SUBSPACES_DEF);
            4:       data[NSUB_W-1:0] = '1;
            5, 6:    data[NSUB_W-1:0] = NSUB_W'($urandom_range(126, MAX_SUBSPACES_DEF + 1));
            7, 8, 9: data[NSUB_W-1:0] = NSUB_W'($urandom_range(MAX_SUBSPACES_DEF, 9));
            default: data[NSUB_W-1:0] = NSUB_W'($urandom_range(8, 1));
        endcase
        return data;
    endfunction

    // Prefer centroids whose entries are already loaded, so loads stay a minority
    function automatic int pick_centroid(input int slot);
        int cid;
        cid = $urandom_range(centroids() - 1, 0);
        if ($urandom_range(3, 0) != 0)
            for (int t = 0; t < 8 && !dist_written[ADDR_W'(slot * centroids() + cid)]; t++)
                cid = $urandom_range(centroids() - 1, 0);
        return cid;
    endfunction

    function automatic int words_needed();
        int active;
        active = active_slots();
        return (active == 0) ? 1 : (active + codes_per_word() - 1) / codes_per_word();
    endfunction

    // Offer one request after a random gap; return once it is accepted
    task automatic send_request(input t_opcode op, input logic [ADDR_W-1:0] idx,
                                input logic [VALUE_W-1:0] val, input logic [WORD_W-1:0] word,
                                input logic last);
        int gap;
        gap = (send_gap_max > 0) ? $urandom_range(send_gap_max, 0) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, word, val, idx};
        s_axis_tuser  <= op;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        requests_sent++;
        accumulate_distance(op, idx, val, word, last);
    endtask

    task automatic send_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Load an entry before a code reads it; a read of a never-loaded entry is off limits
    task automatic ensure_written(input logic [ADDR_W-1:0] addr);
        if (!dist_written[addr])
            send_request(OP_TABLE_WRITE, addr, draw_value(), {$urandom, $urandom},
                         1'($urandom_range(1, 0)));
    endtask

    // Build a code word with random content; loads of missing entries go in between
    task automatic send_code_word(input logic last);
        logic [WORD_W-1:0] word;
        int slot;
        int cid;
        word = {$urandom, $urandom};
        for (int j = 0; j < codes_per_word(); j++) begin
            slot = scan_slots + j;
            if (slot < active_slots()) begin
                cid = pick_centroid(slot);
                if (cfg_mode8)
                    word[BYTE_W*j +: BYTE_W] = BYTE_W'(cid);
                else
                    word[NIBBLE_W*j +: NIBBLE_W] = NIBBLE_W'(cid);
                ensure_written(ADDR_W'(slot * centroids() + cid));
            end
        end
        send_request(OP_CODE_WORD, ADDR_W'($urandom), $urandom, word, last);
    endtask

    task automatic send_vector(input int words);
        for (int w = 0; w < words; w++)
            send_code_word(w == words - 1);
    endtask

    // Hold the input idle until every queued distance is back, then let the pipe settle
    task automatic wait_for_results();
        int waited;
        send_idle();
        waited = 0;
        while (pending_distances.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (pending_distances.size() != 0) begin
            report_mismatch($sformatf("%0d distances never arrived", pending_distances.size()));
            pending_distances.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // APB write, then read back; only call with the scan idle
    task automatic write_register(input t_reg_idx idx, input logic [APB_DATA_W-1:0] data);
        logic [APB_DATA_W-1:0] readback_want;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(4 * int'(idx));
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (idx == REG_CODE_BITS_MODE)
            cfg_mode8 = data[0];
        else
            cfg_nsub = data[NSUB_W-1:0];
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        readback_want = (idx == REG_CODE_BITS_MODE) ? APB_DATA_W'(cfg_mode8)
                                                    : APB_DATA_W'(cfg_nsub);
        if (prdata !== readback_want)
            report_mismatch($sformatf("register %s read %h, want %h", idx.name(), prdata,
                                      readback_want));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Reset registers: extreme entries at centroids 0 and 255, one 8-slot vector
    task automatic test_default_config();
        for (int s = 0; s < 8; s++)
            send_request(OP_TABLE_WRITE, ADDR_W'(s * MAX_CENTROIDS_DEF + ((s % 2) ? 255 : 0)),
                         (s % 2) ? VALUE_MIN : VALUE_MAX, {$urandom, $urandom}, s == 7);
        send_request(OP_TABLE_WRITE, '1, VALUE_MIN, '1, 1'b1);
        send_request(OP_CODE_WORD, '1, '1, ALT_BYTES, 1'b1);
        wait_for_results();
    endtask

    // Codes past the subspace count, in the same word and in a later word
    task automatic test_surplus_slots();
        write_register(REG_NUM_SUBSPACES, 32'd3);
        send_request(OP_CODE_WORD, '0, '0, ALT_BYTES, 1'b1);
        send_request(OP_CODE_WORD, ADDR_W'($urandom), $urandom, ALT_BYTES, 1'b0);
        send_request(OP_CODE_WORD, ADDR_W'($urandom), $urandom, {$urandom, $urandom}, 1'b1);
        wait_for_results();
    endtask

    // Last word before all subspaces are covered
    task automatic test_short_code();
        write_register(REG_NUM_SUBSPACES, 32'd12);
        send_request(OP_CODE_WORD, '0, '0, ALT_BYTES, 1'b1);
        wait_for_results();
    endtask

    // Loads between the words of one vector must not disturb it; the newest value wins
    task automatic test_write_mid_vector();
        send_request(OP_CODE_WORD, '0, '0, ALT_BYTES, 1'b0);
        send_request(OP_TABLE_WRITE, ADDR_W'(8 * MAX_CENTROIDS_DEF), VALUE_MIN, '0, 1'b1);
        send_request(OP_TABLE_WRITE, ADDR_W'(8 * MAX_CENTROIDS_DEF), 32'h1234_5678, '1, 1'b0);
        for (int s = 9; s < 12; s++)
            ensure_written(ADDR_W'(s * MAX_CENTROIDS_DEF));
        send_request(OP_CODE_WORD, '1, '1, '0, 1'b1);
        wait_for_results();
    endtask

    // Count zero: nothing summed, distance zero, not short
    task automatic test_zero_subspaces();
        write_register(REG_NUM_SUBSPACES, 32'hFFFF_FF80);
        send_request(OP_CODE_WORD, '0, '0, {$urandom, $urandom}, 1'b0);
        send_request(OP_CODE_WORD, '0, '0, {$urandom, $urandom}, 1'b1);
        wait_for_results();
    endtask

    // 4-bit codes, low nibble first, 16 centroids per subspace
    task automatic test_nibble_mode();
        logic [WORD_W-1:0] word;
        write_register(REG_CODE_BITS_MODE, 32'h0);
        write_register(REG_NUM_SUBSPACES, 32'd4);
        send_request(OP_TABLE_WRITE, ADDR_W'(31), VALUE_MAX, '0, 1'b0);
        send_request(OP_TABLE_WRITE, ADDR_W'(63), VALUE_MIN, '0, 1'b0);
        ensure_written(ADDR_W'(0));
        ensure_written(ADDR_W'(32));
        word = {$urandom, $urandom};
        word[15:0] = 16'hF0F0;
        send_request(OP_CODE_WORD, '0, '0, word, 1'b1);
        wait_for_results();
    endtask

    // Random phases: new registers, idling pattern and a batch of vectors each
    task automatic test_random_scan();
        int first;
        int words;
        int pick;
        first = requests_sent;
        while (requests_sent - first < RANDOM_REQUESTS) begin
            write_register(REG_CODE_BITS_MODE, $urandom);
            write_register(REG_NUM_SUBSPACES, draw_subspaces());
            send_gap_max = draw_gap_limit();
            recv_gap_max = draw_gap_limit();
            repeat ($urandom_range(20, 4)) begin
                if ($urandom_range(9, 0) == 0) begin
                    send_request(OP_TABLE_WRITE, ADDR_W'($urandom), draw_value(),
                                 {$urandom, $urandom}, 1'($urandom_range(1, 0)));
                end else begin
                    words = words_needed();
                    pick = $urandom_range(9, 0);
                    // Mostly well-formed vectors; some cut short, some overlong
                    if (pick == 0 && words > 1)
                        words = $urandom_range(words - 1, 1);
                    else if (pick == 1)
                        words += $urandom_range(2, 1);
                    send_vector(words);
                end
            end
            wait_for_results();
        end
        send_gap_max = 18;
        recv_gap_max = 18;
    endtask

    // Counts above the maximum saturate to the maximum
    task automatic test_saturated_count();
        write_register(REG_CODE_BITS_MODE, 32'h0);
        write_register(REG_NUM_SUBSPACES, 32'd127);
        send_vector(words_needed());
        send_vector(words_needed() - 1);
        send_vector(words_needed() + 1);
        wait_for_results();
        write_register(REG_CODE_BITS_MODE, 32'h1);
        write_register(REG_NUM_SUBSPACES, 32'd100);
        send_vector(words_needed());
        wait_for_results();
    endtask

    // Sink holds off for a long stretch while short vectors stream in back to back
    task automatic test_backpressure();
        write_register(REG_CODE_BITS_MODE, 32'h1);
        write_register(REG_NUM_SUBSPACES, 32'd4);
        send_gap_max = 0;
        recv_gap_max = 0;
        sink_hold_left = LONG_HOLD_CYCLES;
        repeat (40) send_vector(1);
        wait_for_results();
        send_gap_max = 18;
        recv_gap_max = 18;
    endtask

    // Source pauses until every distance is back, then carries on with the same registers
    task automatic test_sender_pause();
        write_register(REG_CODE_BITS_MODE, 32'h0);
        write_register(REG_NUM_SUBSPACES, 32'd20);
        repeat (10) send_vector(words_needed());
        wait_for_results();
        repeat (10) send_vector(words_needed());
        wait_for_results();
    endtask

    // Result sink: random stall after each accepted distance, plus the long hold-off
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready)
                stall_left = (recv_gap_max > 0) ? $urandom_range(recv_gap_max, 0) : 0;
            else if (stall_left > 0)
                stall_left--;
            if (sink_hold_left > 0)
                sink_hold_left--;
            m_axis_tready <= (stall_left == 0 && sink_hold_left == 0);
        end
    end

    // Compare each accepted distance with the oldest prediction
    always @(posedge i_clk) begin : distance_check
        t_scan_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_distances.size() == 0) begin
                report_mismatch($sformatf("unexpected distance %h", m_axis_tdata));
            end else begin
                want = pending_distances.pop_front();
                if (m_axis_tdata !== want.distance)
                    report_mismatch($sformatf("distance %h, want %h", m_axis_tdata,
                                              want.distance));
                if (m_axis_tuser[0] !== want.short_code)
                    report_mismatch($sformatf("short_code %b, want %b", m_axis_tuser[0],
                                              want.short_code));
            end
        end
    end

    initial begin : run_tests
        cfg_mode8 = MODE_RESET;
        cfg_nsub = NSUB_RESET;
        scan_sum = '0;
        scan_slots = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_config();
        test_surplus_slots();
        test_short_code();
        test_write_mid_vector();
        test_zero_subspaces();
        test_nibble_mode();
        test_random_scan();
        test_saturated_count();
        test_backpressure();
        test_sender_pause();
        wait_for_results();
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("Test completed with failures");
        $finish;
    end

endmodule
